// ===== rtl/mabt_pkg.sv =====
`default_nettype none
package mabt_pkg;

	localparam int MAC_W       = 48;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// request operation codes
	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2
	} status_t;

	// classified request as handed from front to back
	typedef struct packed {
		logic             is_add;
		logic             is_remove;
		logic             is_clear;
		logic [MAC_W-1:0] mac;
	} cmd_t;

	// one table word
	typedef struct packed {
		logic             valid;
		logic [MAC_W-1:0] addr;
	} entry_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_SCAN,
		BK_APPLY,
		BK_SWEEP,
		BK_REPLY
	} back_state_t;

endpackage
`default_nettype wire

// ===== rtl/mabt_req_if.sv =====
`default_nettype none
interface mabt_req_if;
	logic                   valid;
	logic                   ready;
	logic [1:0]             kind;
	logic [mabt_pkg::MAC_W-1:0] mac;

	modport source (output valid, output kind, output mac, input ready);
	modport sink   (input valid, input kind, input mac, output ready);
endinterface
`default_nettype wire

// ===== rtl/mabt_rsp_if.sv =====
`default_nettype none
interface mabt_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       present;

	modport source (output valid, output status, output present, input ready);
	modport sink   (input valid, input status, input present, output ready);
endinterface
`default_nettype wire

// ===== rtl/mac_address_block_table_core.sv =====
// station address table: holds up to TABLE_ENTRIES 48-bit MAC addresses
//
// channels
//   req: valid/ready request carrying kind (lookup, add, remove, clear) and mac
//   rsp: valid/ready result carrying status (ok, not found, full) and present
//   every request yields exactly one result, in request order
// timing
//   the front stage takes a request per cycle, unless it holds one the queue
//   has no room for, into a two-deep queue; the back scans the table memory
//   one entry per cycle through its single read port; a clear then sweeps
//   the table, writing one entry a cycle; the back works on one request at a
//   time and takes the next from the queue only once its result is loaded
// reset
//   arst_n clears control state; the back then sweeps all TABLE_ENTRIES
//   entries invalid, one per cycle, and takes no request from the queue
//   until the sweep is done (requests still enter the queue meanwhile)
// stalls
//   a result waits in the output register while rsp.ready is low; the back
//   holds its next result, the queue and front fill, then req.ready drops
`default_nettype none
module mac_address_block_table_core #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mabt_req_if.sink  req,
	mabt_rsp_if.source rsp
);

	// front to queue
	mabt_pkg::cmd_t front_cmd;
	logic           front_valid;
	logic           front_ready;

	// queue to back
	mabt_pkg::cmd_t back_cmd;
	logic           back_valid;
	logic           back_ready;

	// accepts requests and decodes the operation
	mabt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	// decouples intake from the table sequencer
	mabt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_cmd    (back_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// scans the table, applies the update and registers the result
	mabt_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ===== rtl/mabt_front.sv =====
`default_nettype none
module mabt_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	mabt_req_if.sink            req,
	output mabt_pkg::cmd_t      cmd,
	output logic                cmd_valid,
	input  wire logic           cmd_ready
);

	logic           valid_s1;
	mabt_pkg::cmd_t cmd_s1;
	mabt_pkg::cmd_t cmd_d;
	logic           take;

	assign req.ready = !valid_s1 || cmd_ready;
	assign take      = req.valid && req.ready;

	// decode the operation into flags
	always_comb begin
		cmd_d           = '0;
		cmd_d.mac       = req.mac;
		unique case (mabt_pkg::kind_t'(req.kind))
			mabt_pkg::KIND_ADD:    cmd_d.is_add    = 1'b1;
			mabt_pkg::KIND_REMOVE: cmd_d.is_remove = 1'b1;
			mabt_pkg::KIND_CLEAR:  cmd_d.is_clear  = 1'b1;
			default:               cmd_d.mac       = req.mac;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign cmd       = cmd_s1;
	assign cmd_valid = valid_s1;

endmodule
`default_nettype wire

// ===== rtl/mabt_queue.sv =====
`default_nettype none
module mabt_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mabt_pkg::cmd_t push_cmd,
	input  wire logic           push_valid,
	output logic                push_ready,
	output mabt_pkg::cmd_t      pop_cmd,
	output logic                pop_valid,
	input  wire logic           pop_ready
);

	mabt_pkg::cmd_t                      fifo_q [mabt_pkg::QUEUE_DEPTH];
	logic [mabt_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [mabt_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [mabt_pkg::QUEUE_CNT_W-1:0]    count_q;
	logic                                push;
	logic                                pop;

	localparam logic [mabt_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
		mabt_pkg::QUEUE_PTR_W'(mabt_pkg::QUEUE_DEPTH - 1);
	localparam logic [mabt_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
		mabt_pkg::QUEUE_CNT_W'(mabt_pkg::QUEUE_DEPTH);

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");

	a_pop_follows_push: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 && !push) |=> !pop_valid)
		else $error("queue shows an entry that was never pushed");

endmodule
`default_nettype wire

// ===== rtl/mabt_back.sv =====
`default_nettype none
module mabt_back #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mabt_pkg::cmd_t cmd,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	mabt_rsp_if.source          rsp
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(TABLE_ENTRIES);

	mabt_pkg::entry_t      table_q [TABLE_ENTRIES];
	mabt_pkg::back_state_t state_q;
	mabt_pkg::back_state_t state_d;
	logic [CNT_W-1:0]      cnt_q;
	logic                  rd_valid_q;
	logic [IDX_W-1:0]      rd_idx_q;
	mabt_pkg::entry_t      rdata_q;
	mabt_pkg::cmd_t        cur_q;
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic                  free_found_q;
	logic [IDX_W-1:0]      free_idx_q;
	mabt_pkg::status_t     res_status_q;
	logic                  res_present_q;
	logic                  out_valid_q;
	mabt_pkg::status_t     out_status_q;
	logic                  out_present_q;

	logic                  rd_en;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	mabt_pkg::entry_t      wr_data;
	logic                  load_out;
	logic                  take;
	logic                  entry_match;
	logic                  entry_free;
	mabt_pkg::status_t     status_d;

	assign take        = cmd_valid && cmd_ready;
	assign entry_match = rd_valid_q && rdata_q.valid && (rdata_q.addr == cur_q.mac);
	assign entry_free  = rd_valid_q && !rdata_q.valid;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mabt_pkg::BK_INIT: begin
				if (cnt_q == LAST_CNT) state_d = mabt_pkg::BK_IDLE;
			end
			mabt_pkg::BK_IDLE: begin
				if (cmd_valid) state_d = mabt_pkg::BK_SCAN;
			end
			mabt_pkg::BK_SCAN: begin
				if (cnt_q == END_CNT && !rd_valid_q) state_d = mabt_pkg::BK_APPLY;
			end
			mabt_pkg::BK_APPLY: begin
				state_d = cur_q.is_clear ? mabt_pkg::BK_SWEEP : mabt_pkg::BK_REPLY;
			end
			mabt_pkg::BK_SWEEP: begin
				if (cnt_q == LAST_CNT) state_d = mabt_pkg::BK_REPLY;
			end
			mabt_pkg::BK_REPLY: begin
				if (load_out) state_d = mabt_pkg::BK_IDLE;
			end
			default: state_d = mabt_pkg::BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_ready    = 1'b0;
		rd_en        = 1'b0;
		wr_en        = 1'b0;
		wr_idx       = cnt_q[IDX_W-1:0];
		wr_data      = '{valid: 1'b0, addr: cur_q.mac};
		load_out     = 1'b0;
		unique case (state_q) inside
			mabt_pkg::BK_INIT, mabt_pkg::BK_SWEEP: begin
				wr_en = 1'b1;
			end
			mabt_pkg::BK_IDLE: begin
				cmd_ready = 1'b1;
			end
			mabt_pkg::BK_SCAN: begin
				rd_en = (cnt_q < END_CNT);
			end
			mabt_pkg::BK_APPLY: begin
				if (cur_q.is_add && !hit_q && free_found_q) begin
					wr_en   = 1'b1;
					wr_idx  = free_idx_q;
					wr_data = '{valid: 1'b1, addr: cur_q.mac};
				end else if (cur_q.is_remove && hit_q) begin
					wr_en  = 1'b1;
					wr_idx = hit_idx_q;
				end
			end
			mabt_pkg::BK_REPLY: begin
				load_out = !out_valid_q || rsp.ready;
			end
			default: cmd_ready = 1'b0;
		endcase
	end

	always_comb begin
		status_d = mabt_pkg::STATUS_OK;
		if (cur_q.is_add && !hit_q && !free_found_q) begin
			status_d = mabt_pkg::STATUS_FULL;
		end else if (cur_q.is_remove && !hit_q) begin
			status_d = mabt_pkg::STATUS_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mabt_pkg::BK_INIT;
			cnt_q        <= '0;
			rd_valid_q   <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_valid_q <= rd_en;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (rd_en || state_q == mabt_pkg::BK_INIT
					|| state_q == mabt_pkg::BK_SWEEP) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (take) begin
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (entry_match && !hit_q)       hit_q        <= 1'b1;
				if (entry_free && !free_found_q) free_found_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= cnt_q[IDX_W-1:0];
		if (take) begin
			cur_q <= cmd;
		end
		if (!take && entry_match && !hit_q) begin
			hit_idx_q <= rd_idx_q;
		end
		if (!take && entry_free && !free_found_q) begin
			free_idx_q <= rd_idx_q;
		end
		if (state_q == mabt_pkg::BK_APPLY) begin
			res_status_q  <= status_d;
			res_present_q <= hit_q;
		end
		if (load_out) begin
			out_status_q  <= res_status_q;
			out_present_q <= res_present_q;
		end
	end

	// table memory: one read port, one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= table_q[cnt_q[IDX_W-1:0]];
		end
		if (wr_en) begin
			table_q[wr_idx] <= wr_data;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_status_q;
	assign rsp.present = out_present_q;

	a_hit_free_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_q && free_found_q) |-> (hit_idx_q != free_idx_q))
		else $error("matching entry also recorded as free");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mabt_pkg::BK_APPLY && cur_q.is_add && !hit_q && !free_found_q)
		|=> (res_status_q == mabt_pkg::STATUS_FULL))
		else $error("add without free entry not reported full");

	a_no_reply_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mabt_pkg::BK_INIT) |-> !out_valid_q)
		else $error("result shown during clearing pass");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_q |-> (state_q == mabt_pkg::BK_SCAN))
		else $error("table read data outside scan");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam int TABLE_N      = 64;
	// a clear is the slowest request: sweep plus scan plus overhead
	localparam int SETTLE_TICKS = 2 * TABLE_N + 16;
	localparam int POOL_N       = 96;
	localparam int RANDOM_ITEMS = 1336;

	// receiver back-pressure patterns
	typedef enum int {
		RX_STEADY,
		RX_RANDOM,
		RX_BURSTY
	} rx_mode_t;

	// what the table should answer for one request
	typedef struct {
		mabt_pkg::status_t status;
		logic              present;
	} reply_t;

	logic clk;
	logic arst_n;

	mabt_req_if req ();
	mabt_rsp_if rsp ();

	mac_address_block_table_core #(
		.TABLE_ENTRIES(TABLE_N)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// shadow copy of the station table
	logic [mabt_pkg::MAC_W-1:0] station_addr [TABLE_N];
	bit                         station_used [TABLE_N];
	int                         station_count;

	// replies owed by the block, oldest first
	reply_t pending_replies [$];
	int     fail_count = 0;

	// sender burst shaping and receiver stall pattern
	bit       tx_gaps;
	int       burst_left;
	rx_mode_t rx_mode;
	int       stall_left = 0;

	// address pool so that adds, removes and lookups actually hit each other
	logic [mabt_pkg::MAC_W-1:0] mac_pool [POOL_N];

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// update the shadow table for one accepted request and return the reply it owes
	function automatic reply_t apply_request(mabt_pkg::kind_t op,
		logic [mabt_pkg::MAC_W-1:0] mac);
		reply_t r;
		int     hit;
		int     slot;
		hit  = -1;
		slot = -1;
		for (int i = 0; i < TABLE_N; i++) begin
			if (station_used[i] && station_addr[i] == mac && hit < 0)
				hit = i;
			if (!station_used[i] && slot < 0)
				slot = i;
		end
		r.status  = mabt_pkg::STATUS_OK;
		r.present = (hit >= 0);
		case (op)
			mabt_pkg::KIND_ADD: begin
				// already held: nothing to do; otherwise lowest free slot or full
				if (hit < 0) begin
					if (slot < 0) begin
						r.status = mabt_pkg::STATUS_FULL;
					end else begin
						station_addr[slot] = mac;
						station_used[slot] = 1'b1;
						station_count++;
					end
				end
			end
			mabt_pkg::KIND_REMOVE: begin
				if (hit < 0) begin
					r.status = mabt_pkg::STATUS_NOT_FOUND;
				end else begin
					station_used[hit] = 1'b0;
					station_count--;
				end
			end
			mabt_pkg::KIND_CLEAR: begin
				// present still reflects the table before the wipe
				for (int i = 0; i < TABLE_N; i++)
					station_used[i] = 1'b0;
				station_count = 0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic [mabt_pkg::MAC_W-1:0] random_mac();
		return {16'($urandom()), 32'($urandom())};
	endfunction

	// drive one request, hold it until the handshake, then record the owed reply
	task automatic send_request(mabt_pkg::kind_t op, logic [mabt_pkg::MAC_W-1:0] mac);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = tx_gaps ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				@(negedge clk);
				req.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.kind  <= op;
		req.mac   <= mac;
		do
			@(posedge clk);
		while (!req.ready);
		pending_replies.push_back(apply_request(op, mac));
		burst_left--;
	endtask

	// drop valid, let every owed reply come back, then give the block time to go quiet
	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// receiver: drives ready on the falling edge according to the current pattern
	always @(negedge clk) begin
		case (rx_mode)
			RX_STEADY: rsp.ready <= 1'b1;
			RX_RANDOM: rsp.ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					rsp.ready <= 1'b0;
				end else if ($urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 24);
					rsp.ready <= 1'b0;
				end else begin
					rsp.ready <= 1'b1;
				end
			end
		endcase
	end

	// reply checker: each accepted reply against the oldest owed one
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected reply: status=%0d present=%0b", rsp.status, rsp.present);
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				if (rsp.status !== want.status) begin
					$error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.present !== want.present) begin
					$error("present mismatch: expected %0b, got %0b",
						want.present, rsp.present);
					fail_count++;
				end
			end
		end
	end

	// corner cases on a near-empty table
	task automatic test_directed();
		logic [mabt_pkg::MAC_W-1:0] ones;
		ones       = '1;
		tx_gaps    = 1'b0;
		rx_mode    = RX_STEADY;
		// empty table: lookups miss, remove reports not found
		send_request(mabt_pkg::KIND_LOOKUP, '0);
		send_request(mabt_pkg::KIND_LOOKUP, ones);
		send_request(mabt_pkg::KIND_REMOVE, ones);
		// both extremes go in, re-add of a held address is a quiet success
		send_request(mabt_pkg::KIND_ADD, '0);
		send_request(mabt_pkg::KIND_ADD, ones);
		send_request(mabt_pkg::KIND_ADD, '0);
		send_request(mabt_pkg::KIND_LOOKUP, '0);
		send_request(mabt_pkg::KIND_LOOKUP, ones);
		// alternating bit patterns must not alias the held ones
		send_request(mabt_pkg::KIND_LOOKUP, 48'hAAAA_AAAA_AAAA);
		send_request(mabt_pkg::KIND_LOOKUP, 48'h5555_5555_5555);
		send_request(mabt_pkg::KIND_ADD, 48'h5555_5555_5555);
		send_request(mabt_pkg::KIND_LOOKUP, 48'hFFFF_FFFF_FFFE);
		// remove then remove again
		send_request(mabt_pkg::KIND_REMOVE, '0);
		send_request(mabt_pkg::KIND_REMOVE, '0);
		send_request(mabt_pkg::KIND_LOOKUP, '0);
		// freed slot is reused by the next add
		send_request(mabt_pkg::KIND_ADD, 48'hAAAA_AAAA_AAAA);
		send_request(mabt_pkg::KIND_LOOKUP, 48'hAAAA_AAAA_AAAA);
		// clear reports whether its own address was held before the wipe
		send_request(mabt_pkg::KIND_CLEAR, ones);
		send_request(mabt_pkg::KIND_LOOKUP, ones);
		send_request(mabt_pkg::KIND_CLEAR, 48'h0123_4567_89AB);
		send_request(mabt_pkg::KIND_LOOKUP, 48'h5555_5555_5555);
		drain();
	endtask

	// fill the table up, push past full, free a slot and refill it
	task automatic test_fill();
		logic [mabt_pkg::MAC_W-1:0] mac;
		tx_gaps = 1'b1;
		rx_mode = RX_RANDOM;
		while (station_count < TABLE_N) begin
			mac = random_mac();
			send_request(mabt_pkg::KIND_ADD, mac);
			if ($urandom_range(0, 4) == 0)
				send_request(mabt_pkg::KIND_ADD, mac);
		end
		// every slot taken: new addresses bounce, held ones still succeed
		repeat (6) send_request(mabt_pkg::KIND_ADD, random_mac());
		send_request(mabt_pkg::KIND_ADD, station_addr[$urandom_range(0, TABLE_N - 1)]);
		send_request(mabt_pkg::KIND_ADD, station_addr[TABLE_N - 1]);
		send_request(mabt_pkg::KIND_LOOKUP, station_addr[0]);
		send_request(mabt_pkg::KIND_LOOKUP, station_addr[TABLE_N - 1]);
		// one hole, one refill, then full again
		mac = station_addr[$urandom_range(0, TABLE_N - 1)];
		send_request(mabt_pkg::KIND_REMOVE, mac);
		send_request(mabt_pkg::KIND_LOOKUP, mac);
		send_request(mabt_pkg::KIND_ADD, random_mac());
		send_request(mabt_pkg::KIND_ADD, random_mac());
		send_request(mabt_pkg::KIND_CLEAR, station_addr[0]);
		send_request(mabt_pkg::KIND_LOOKUP, station_addr[0]);
		drain();
	endtask

	// random traffic over a shared address pool, phases vary mix and idling
	task automatic test_random(int items);
		int                         per_phase;
		int                         pick;
		int                         src;
		mabt_pkg::kind_t            op;
		logic [mabt_pkg::MAC_W-1:0] mac;
		per_phase = items / 6;
		for (int i = 0; i < POOL_N; i++)
			mac_pool[i] = random_mac();
		for (int phase = 0; phase < 6; phase++) begin
			// phases 0 and 2 have no sender gaps, phases 0 and 3 no receiver stalls
			tx_gaps = (phase != 0 && phase != 2);
			rx_mode = rx_mode_t'(phase % 3);
			repeat (per_phase) begin
				pick = $urandom_range(0, 99);
				case (phase % 3)
					// add-heavy: drives the table into the full state
					1: op = (pick < 60) ? mabt_pkg::KIND_ADD :
						(pick < 75) ? mabt_pkg::KIND_REMOVE :
						(pick < 99) ? mabt_pkg::KIND_LOOKUP : mabt_pkg::KIND_CLEAR;
					// remove-heavy: drains it back down
					2: op = (pick < 25) ? mabt_pkg::KIND_ADD :
						(pick < 80) ? mabt_pkg::KIND_REMOVE :
						(pick < 99) ? mabt_pkg::KIND_LOOKUP : mabt_pkg::KIND_CLEAR;
					default: op = (pick < 35) ? mabt_pkg::KIND_ADD :
						(pick < 68) ? mabt_pkg::KIND_REMOVE :
						(pick < 98) ? mabt_pkg::KIND_LOOKUP : mabt_pkg::KIND_CLEAR;
				endcase
				src = $urandom_range(0, 9);
				if (src == 0)
					mac = random_mac();
				else if (src == 1)
					// near miss: one bit off a pool address
					mac = mac_pool[$urandom_range(0, POOL_N - 1)] ^
						(48'd1 << $urandom_range(0, mabt_pkg::MAC_W - 1));
				else
					mac = mac_pool[$urandom_range(0, POOL_N - 1)];
				send_request(op, mac);
			end
			drain();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.kind      = mabt_pkg::KIND_LOOKUP;
		req.mac       = '0;
		station_count = 0;
		burst_left    = 0;
		tx_gaps       = 1'b0;
		rx_mode       = RX_STEADY;
		for (int i = 0; i < TABLE_N; i++) begin
			station_addr[i] = '0;
			station_used[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// requests sent right away simply queue behind the post-reset sweep
		test_directed();
		test_fill();
		test_random(RANDOM_ITEMS);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mabt_pkg.sv
rtl/mabt_req_if.sv
rtl/mabt_rsp_if.sv
rtl/mabt_front.sv
rtl/mabt_queue.sv
rtl/mabt_back.sv
rtl/mac_address_block_table_core.sv
verif/tb.sv
